>>> rtl/ecgrp_pkg.sv
// ----------------------------------------------------------------------------
// ecgrp_pkg: shared types and constants of the ecg r-peak detector
// register indexes, counter limits, fixed field widths and the config struct
// ----------------------------------------------------------------------------
package ecgrp_pkg;

  localparam int FRAC_BITS  = 6;
  localparam int OUT_W      = 33;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int WARM_W     = 10;
  localparam int SINCE_W    = 11;
  localparam int HIST_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 1'b1;

  localparam logic [CFG_W-1:0]   REFRACTORY_RESET = 10'd50;
  localparam logic [CFG_W-1:0]   WARMUP_RESET     = 10'd125;
  localparam logic [WARM_W-1:0]  WARM_MAX         = '1;
  localparam logic [SINCE_W-1:0] SINCE_MAX        = '1;

  typedef struct packed {
    logic [CFG_W-1:0] refractory;
    logic [CFG_W-1:0] warmup;
  } cfg_t;

endpackage

>>> rtl/ecgrp_cell.sv
// ----------------------------------------------------------------------------
// ecgrp_cell: one cell of a delay chain
// holds one value and passes it to the next cell on each shift
// ----------------------------------------------------------------------------
module ecgrp_cell #(
  parameter int W = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         shift,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

>>> rtl/ecgrp_front.sv
// ----------------------------------------------------------------------------
// ecgrp_front: sample history chain, five-point derivative and square
// the derivative is registered on the input transfer, the square one step later
// ----------------------------------------------------------------------------
module ecgrp_front #(
  parameter int SAMPLE_BITS = 12,
  parameter int DIFF_W      = 15,
  parameter int SQ_W        = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          step,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [SQ_W-1:0]               sq
);
  import ecgrp_pkg::*;

  localparam int MAG_W = DIFF_W - 1;

  logic [SAMPLE_BITS-1:0]   tap [HIST_DEPTH];
  logic signed [DIFF_W-1:0] diff_c;
  logic signed [DIFF_W-1:0] diff;
  logic [MAG_W-1:0]         mag;
  logic [SQ_W-1:0]          prod;

  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_hist
    if (k == 0) begin : g_head
      ecgrp_cell #(.W(SAMPLE_BITS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (load),
        .d     (sample),
        .q     (tap[k])
      );
    end else begin : g_body
      ecgrp_cell #(.W(SAMPLE_BITS)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (load),
        .d     (tap[k-1]),
        .q     (tap[k])
      );
    end
  end

  // 2*x[n] + x[n-1] - x[n-3] - 2*x[n-4]
  always_comb begin
    diff_c = (DIFF_W'(sample) <<< 1)
           + DIFF_W'($signed(tap[0]))
           - DIFF_W'($signed(tap[2]))
           - (DIFF_W'($signed(tap[3])) <<< 1);
  end

  // square of the magnitude
  assign mag  = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign prod = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (load) begin
      diff <= diff_c;
    end
    if (step) begin
      sq <= prod;
    end
  end

endmodule

>>> rtl/ecgrp_window.sv
// ----------------------------------------------------------------------------
// ecgrp_window: moving window of squared derivatives
// a chain of cells carries the window, the running sum drops the oldest value
// ----------------------------------------------------------------------------
module ecgrp_window #(
  parameter int WINDOW = 37,
  parameter int SQ_W   = 28,
  parameter int SUM_W  = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [SQ_W-1:0]  sq,
  output logic [SUM_W-1:0] energy
);

  logic [SQ_W-1:0]  tap [WINDOW];
  logic [SUM_W-1:0] energy_next;

  for (genvar k = 0; k < WINDOW; k++) begin : g_win
    if (k == 0) begin : g_head
      ecgrp_cell #(.W(SQ_W)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (sq),
        .q     (tap[k])
      );
    end else begin : g_body
      ecgrp_cell #(.W(SQ_W)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (tap[k-1]),
        .q     (tap[k])
      );
    end
  end

  assign energy_next = energy - SUM_W'(tap[WINDOW-1]) + SUM_W'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= '0;
    end else if (shift) begin
      energy <= energy_next;
    end
  end

endmodule

>>> rtl/ecgrp_detect.sv
// ----------------------------------------------------------------------------
// ecgrp_detect: adaptive threshold and peak decision
// warm-up and refractory counters, signal and noise levels, result register
// ----------------------------------------------------------------------------
module ecgrp_detect #(
  parameter int SUM_W = 34,
  parameter int LVL_W = 41
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  ecgrp_pkg::cfg_t               cfg,
  input  logic [SUM_W-1:0]              energy,
  output logic                          r_peak,
  output logic [ecgrp_pkg::OUT_W-1:0]   window_energy,
  output logic [ecgrp_pkg::OUT_W-1:0]   threshold_level
);
  import ecgrp_pkg::*;

  logic [WARM_W-1:0]  warm,  warm_inc,  warm_next;
  logic [SINCE_W-1:0] since, since_inc, since_next;
  logic [LVL_W-1:0]   sig,   sig_next,  sig_upd;
  logic [LVL_W-1:0]   noise, noise_next, noise_upd;
  logic [LVL_W-1:0]   thr,   thr_next;
  logic [LVL_W-1:0]   e;
  logic               armed;
  logic               refr_done;
  logic               peak_next;

  // (e + 7*lv) >> 3
  function automatic logic [LVL_W-1:0] level_update(input logic [LVL_W-1:0] ev,
                                                    input logic [LVL_W-1:0] lv);
    logic [LVL_W+2:0] acc;
    acc = ({3'b000, lv} << 3) - {3'b000, lv} + {3'b000, ev};
    return acc[LVL_W+2:3];
  endfunction

  function automatic logic [LVL_W-1:0] threshold(input logic [LVL_W-1:0] s,
                                                 input logic [LVL_W-1:0] n);
    if (s >= n) begin
      return n + ((s - n) >> 2);
    end else begin
      return n - ((n - s) >> 2);
    end
  endfunction

  always_comb begin
    warm_inc  = (warm == WARM_MAX) ? warm : warm + 1'b1;
    since_inc = (since == SINCE_MAX) ? since : since + 1'b1;
    e         = LVL_W'(energy) << FRAC_BITS;
    armed     = (warm_inc >= cfg.warmup);
    refr_done = (SINCE_W'(cfg.refractory) < since_inc);
    sig_upd   = level_update(e, sig);
    noise_upd = level_update(e, noise);

    warm_next  = warm_inc;
    since_next = since_inc;
    sig_next   = sig;
    noise_next = noise;
    thr_next   = thr;
    peak_next  = 1'b0;

    if (armed) begin
      if (sig == '0 && noise == '0) begin
        // levels start at 2e and e/2; folded with the same-sample update
        noise_next = e >> 1;
        if (refr_done) begin
          sig_next  = (e << 1) - (e >> 3);
          thr_next  = e - (e >> 3) - (e >> 5);
          peak_next = (energy != '0);
        end else begin
          sig_next = e << 1;
          thr_next = e - (e >> 3);
        end
      end else if (refr_done) begin
        if (e > thr) begin
          peak_next = 1'b1;
          sig_next  = sig_upd;
          thr_next  = threshold(sig_upd, noise);
        end else begin
          noise_next = noise_upd;
          thr_next   = threshold(sig, noise_upd);
        end
      end
    end

    if (peak_next) begin
      since_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warm  <= '0;
      since <= '0;
      sig   <= '0;
      noise <= '0;
      thr   <= '0;
    end else if (en) begin
      warm  <= warm_next;
      since <= since_next;
      sig   <= sig_next;
      noise <= noise_next;
      thr   <= thr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_peak          <= peak_next;
      window_energy   <= OUT_W'(energy);
      threshold_level <= OUT_W'(thr_next >> FRAC_BITS);
    end
  end

endmodule

>>> rtl/ecg_r_peak_detector.sv
// ----------------------------------------------------------------------------
// ecg_r_peak_detector: qrs detector on a stream of signed ecg samples
// a sample passes the derivative, square, window sum and detector registers in turn
// throughput: one sample per cycle unless every stage is full and the output is blocked;
//   derivative, square, window sum and threshold loop each take one register stage
// reset: synchronous; history and window chains clear at the end of a reset cycle
// ----------------------------------------------------------------------------
module ecg_r_peak_detector #(
  parameter int WINDOW      = 37,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]     sample,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              r_peak,
  output logic [ecgrp_pkg::OUT_W-1:0]       window_energy,
  output logic [ecgrp_pkg::OUT_W-1:0]       threshold_level,
  input  logic                              cfg_write,
  input  logic [ecgrp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ecgrp_pkg::CFG_W-1:0]       cfg_data
);
  import ecgrp_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 3;
  localparam int SQ_W   = 2 * SAMPLE_BITS + 4;
  localparam int SUM_W  = SQ_W + $clog2(WINDOW);
  localparam int LVL_W  = SUM_W + FRAC_BITS + 1;

  cfg_t             cfg;
  logic             v1, v2, v3;
  logic             take1, take2, take3;
  logic             accept;
  logic [SQ_W-1:0]  sq;
  logic [SUM_W-1:0] energy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.refractory <= REFRACTORY_RESET;
      cfg.warmup     <= WARMUP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REFRACTORY: cfg.refractory <= cfg_data;
        REG_WARMUP:     cfg.warmup     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stage handshake, bubbles collapse
  assign take3        = v3 && (!result_valid || result_ready);
  assign take2        = v2 && (!v3 || take3);
  assign take1        = v1 && (!v2 || take2);
  assign sample_ready = !v1 || take1;
  assign accept       = sample_valid && sample_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (take1) begin
        v1 <= 1'b0;
      end
      if (take1) begin
        v2 <= 1'b1;
      end else if (take2) begin
        v2 <= 1'b0;
      end
      if (take2) begin
        v3 <= 1'b1;
      end else if (take3) begin
        v3 <= 1'b0;
      end
      if (take3) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  ecgrp_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DIFF_W      (DIFF_W),
    .SQ_W        (SQ_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .step   (take1),
    .sample (sample),
    .sq     (sq)
  );

  ecgrp_window #(
    .WINDOW (WINDOW),
    .SQ_W   (SQ_W),
    .SUM_W  (SUM_W)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .shift  (take2),
    .sq     (sq),
    .energy (energy)
  );

  ecgrp_detect #(
    .SUM_W (SUM_W),
    .LVL_W (LVL_W)
  ) u_detect (
    .clk             (clk),
    .rst             (rst),
    .en              (take3),
    .cfg             (cfg),
    .energy          (energy),
    .r_peak          (r_peak),
    .window_energy   (window_energy),
    .threshold_level (threshold_level)
  );

  // input stalls only with every stage full and the output blocked
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> (v1 && v2 && v3 && result_valid && !result_ready))
    else $error("input stalled with a free stage");

  // window sum holds while its sample waits for the detector
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !take3) |=> $stable(energy))
    else $error("window sum changed under a waiting sample");

  // a new result only follows a sample in the detector stage
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(v3))
    else $error("result without a sample in the detector stage");

  // the window stage never loads from an empty square stage or over a full detector stage
  a_take_order: assert property (@(posedge clk) disable iff (rst)
    take2 |-> (v2 && (v3 ? take3 : 1'b1)))
    else $error("window stage advanced over a full detector stage");

endmodule
